@@ hdl/decaying_running_average_defines.svh @@
// Assertion macros for the decaying running average checker.
`ifndef DECAYING_RUNNING_AVERAGE_DEFINES_SVH
`define DECAYING_RUNNING_AVERAGE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define DRA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define DRA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/dra_pkg.sv @@
// Shared types and constants of the decaying running average.
package dra_pkg;

  localparam int unsigned FracBitsDef  = 20;
  localparam int unsigned ValueBitsDef = 44;
  localparam logic [31:0] HalfLifeRst  = 32'd1000000000;
  localparam logic [2:0]  AddrHalfLife = 3'd0;

  typedef enum logic [1:0] {
    CMD_ACC   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SCALE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    DIV_T,
    DIV_AT,
    DIV_NHL,
    DIV_NRT,
    DIV_NDT
  } div_sel_e;

  typedef enum logic [2:0] {
    MUL_DUR,
    MUL_FULL,
    MUL_NORM,
    MUL_SV,
    MUL_SO,
    MUL_SC,
    MUL_W
  } mul_sel_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV,
    OP_MUL,
    OP_DELTA,
    OP_DECAY,
    OP_RES_O,
    OP_COMMIT_ACC,
    OP_COMMIT_SCL,
    OP_PUSH
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_DIVT,
    ST_DIVA,
    ST_DELTA,
    ST_DECAY,
    ST_NHL,
    ST_MDUR,
    ST_MFULL,
    ST_NRT,
    ST_MNORM,
    ST_NDT,
    ST_FIN,
    ST_RNRT,
    ST_MW,
    ST_SV,
    ST_SO,
    ST_SC,
    ST_PUSH
  } state_e;

  typedef struct packed {
    op_e      op;
    div_sel_e div_sel;
    mul_sel_e mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic delta_zero;
    logic delta_gt1;
    logic val_zero;
    logic rt_zero;
    logic out_free;
    cmd_e cmd;
  } dp_stat_t;

endpackage

@@ hdl/dra_div.sv @@
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
module dra_div
  import dra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);

  logic [6:0]  cnt_q, cnt_d;
  logic        done_q, done_d;
  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] rem_sh;
  logic        ge;

  assign rem_sh = {rem_q, quo_q[63]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      cnt_d = 7'd64;
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != 7'd0) begin
      quo_d = {quo_q[62:0], ge};
      rem_d = ge ? 32'(rem_sh - {1'b0, dvs_q}) : rem_sh[31:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/dra_mul.sv @@
// Shared 32x32 multiplier giving a saturated, right-shifted 64x32 product.
module dra_mul
  import dra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] x_i,
  input  logic [31:0] m_i,
  input  logic [5:0]  sh_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] x_q, x_d;
  logic [31:0] m_q, m_d;
  logic [5:0]  sh_q, sh_d;
  logic [63:0] lo_q, lo_d;
  logic [63:0] hi_q, hi_d;
  logic [95:0] sum_q, sum_d;
  logic [63:0] res_q, res_d;
  logic [31:0] x_half;
  logic [63:0] prod;
  logic [95:0] shifted;

  assign x_half  = (step_q == 2'd0) ? x_q[31:0] : x_q[63:32];
  assign prod    = 64'(x_half) * 64'(m_q);
  assign shifted = sum_q >> sh_q;

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    x_d    = x_q;
    m_d    = m_q;
    sh_d   = sh_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    sum_d  = sum_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 2'd0;
      x_d    = x_i;
      m_d    = m_i;
      sh_d   = sh_i;
    end else if (busy_q) begin
      step_d = step_q + 2'd1;
      case (step_q)
        2'd0: lo_d = prod;
        2'd1: hi_d = prod;
        2'd2: sum_d = {32'd0, lo_q} + {hi_q, 32'd0};
        default: begin
          res_d  = (shifted[95:64] != 32'd0) ? '1 : shifted[63:0];
          done_d = 1'b1;
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    m_q   <= m_d;
    sh_q  <= sh_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    sum_q <= sum_d;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hdl/dra_dp.sv @@
// Datapath: state, working copies, divider, multiplier and result register.
module dra_dp
  import dra_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dp_cmd_t      cmd_i,
  output dp_stat_t     stat_o,
  input  logic [31:0]  half_life_i,
  input  logic [1:0]   in_cmd_i,
  input  logic [63:0]  in_new_value_i,
  input  logic [63:0]  in_timestamp_i,
  input  logic [31:0]  in_scale_mult_i,
  input  logic [5:0]   in_scale_shift_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [63:0]  out_average_o
);

  localparam logic [63:0] One    = 64'd1 << FRAC_BITS;
  localparam logic [63:0] Lim    = (64'd1 << VALUE_BITS) - 64'd1;
  localparam logic [5:0]  FracSh = 6'(FRAC_BITS);

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] decay(logic [63:0] x, logic [63:0] n);
    return (n >= 64'd64) ? 64'd0 : (x >> n[5:0]);
  endfunction

  cmd_e        cmd_q;
  logic [63:0] t_q, nv_q;
  logic [31:0] mult_q;
  logic [5:0]  sh_q;
  logic [63:0] wv_q, wo_q, wc_q;
  logic [63:0] qt_q, qat_q, nq_q, delta_q;
  logic [31:0] rt_q, rat_q;
  logic [63:0] res_q;
  logic [63:0] held_q, last_q, old_q, cur_q;
  logic [63:0] out_q;
  logic        out_vld_q;
  div_sel_e    div_sel_q;
  mul_sel_e    mul_sel_q;

  logic [31:0] hl_eff;
  logic [63:0] div_in;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] div_rem;
  logic [63:0] mul_x;
  logic [31:0] mul_m;
  logic [5:0]  mul_sh;
  logic        mul_done;
  logic [63:0] mul_res;
  logic [63:0] dm1;
  logic [5:0]  fs_sh;
  logic [63:0] full_sum;
  logic [63:0] dur_dec;
  logic        push;

  assign hl_eff = (half_life_i == 32'd0) ? 32'd1 : half_life_i;
  assign push   = cmd_i.op == OP_PUSH;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_T:   div_in = t_q;
      DIV_AT:  div_in = last_q;
      DIV_NHL: div_in = (64'(hl_eff) - 64'(rat_q)) << FRAC_BITS;
      DIV_NRT: div_in = 64'(rt_q) << FRAC_BITS;
      DIV_NDT: div_in = (t_q - last_q) << FRAC_BITS;
      default: div_in = t_q;
    endcase
  end

  assign dm1      = delta_q - 64'd1;
  assign fs_sh    = (dm1 >= 64'(FRAC_BITS)) ? FracSh : dm1[5:0];
  assign full_sum = One - (One >> fs_sh);
  assign dur_dec  = decay(nq_q, delta_q);

  always_comb begin
    mul_x  = wv_q;
    mul_m  = nq_q[31:0];
    mul_sh = 6'd0;
    case (cmd_i.mul_sel)
      MUL_DUR:  mul_m = dur_dec[31:0];
      MUL_FULL: mul_m = full_sum[31:0];
      MUL_NORM: mul_m = nq_q[31:0];
      MUL_SV: begin
        mul_m  = mult_q;
        mul_sh = sh_q;
      end
      MUL_SO: begin
        mul_x  = wo_q;
        mul_m  = mult_q;
        mul_sh = sh_q;
      end
      MUL_SC: begin
        mul_x  = wc_q;
        mul_m  = mult_q;
        mul_sh = sh_q;
      end
      MUL_W: begin
        mul_x  = wo_q;
        mul_m  = One[31:0] - nq_q[32:1];
        mul_sh = FracSh;
      end
      default: mul_m = nq_q[31:0];
    endcase
  end

  dra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.op == OP_DIV),
    .dividend_i (div_in),
    .divisor_i  (hl_eff),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  dra_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_MUL),
    .x_i     (mul_x),
    .m_i     (mul_m),
    .sh_i    (mul_sh),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q    <= '0;
      last_q    <= '0;
      old_q     <= '0;
      cur_q     <= '0;
      out_vld_q <= 1'b0;
      cmd_q     <= CMD_NOP;
    end else begin
      if (cmd_i.op == OP_LOAD) begin
        cmd_q <= cmd_e'(in_cmd_i);
      end
      if (cmd_i.op == OP_COMMIT_ACC) begin
        held_q <= (nv_q > Lim) ? Lim : nv_q;
        last_q <= t_q;
        old_q  <= wo_q;
        cur_q  <= wc_q;
      end
      if (cmd_i.op == OP_COMMIT_SCL) begin
        held_q <= wv_q;
        old_q  <= wo_q;
        cur_q  <= wc_q;
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      t_q    <= (in_timestamp_i < last_q) ? last_q : in_timestamp_i;
      nv_q   <= in_new_value_i;
      mult_q <= in_scale_mult_i;
      sh_q   <= in_scale_shift_i;
      wv_q   <= held_q;
      wo_q   <= old_q;
      wc_q   <= cur_q;
      res_q  <= '0;
    end
    if (cmd_i.op == OP_DIV) begin
      div_sel_q <= cmd_i.div_sel;
    end
    if (cmd_i.op == OP_MUL) begin
      mul_sel_q <= cmd_i.mul_sel;
    end
    if (cmd_i.op == OP_DELTA) begin
      delta_q <= qt_q - qat_q;
    end
    if (cmd_i.op == OP_DECAY) begin
      wo_q <= sat_add(decay(wo_q, delta_q), decay(wc_q, delta_q));
      wc_q <= '0;
    end
    if (cmd_i.op == OP_RES_O) begin
      res_q <= wo_q;
    end
    if (push) begin
      out_q <= res_q;
    end
    if (div_done) begin
      case (div_sel_q)
        DIV_T: begin
          qt_q <= div_quo;
          rt_q <= div_rem;
        end
        DIV_AT: begin
          qat_q <= div_quo;
          rat_q <= div_rem;
        end
        default: nq_q <= div_quo;
      endcase
    end
    if (mul_done) begin
      case (mul_sel_q)
        MUL_DUR, MUL_FULL: wo_q <= sat_add(wo_q, mul_res);
        MUL_NORM:          wc_q <= sat_add(wc_q, mul_res);
        MUL_SV:            wv_q <= mul_res;
        MUL_SO:            wo_q <= mul_res;
        MUL_SC:            wc_q <= mul_res;
        MUL_W:             res_q <= sat_add(mul_res, wc_q >> 1);
        default:           res_q <= res_q;
      endcase
    end
  end

  assign stat_o.done       = div_done | mul_done;
  assign stat_o.delta_zero = delta_q == 64'd0;
  assign stat_o.delta_gt1  = delta_q > 64'd1;
  assign stat_o.val_zero   = wv_q == 64'd0;
  assign stat_o.rt_zero    = rt_q == 32'd0;
  assign stat_o.out_free   = !out_vld_q || out_ready_i;
  assign stat_o.cmd        = cmd_q;

  assign out_valid_o   = out_vld_q;
  assign out_average_o = out_q;

endmodule

@@ hdl/dra_ctrl.sv @@
// Controller state machine sequencing the datapath for each command.
module dra_ctrl
  import dra_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   wait_q;
  logic   long_op;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DISP;
      ST_DISP: begin
        unique case (stat_i.cmd)
          CMD_ACC, CMD_READ: state_d = ST_DIVT;
          CMD_SCALE:         state_d = ST_SV;
          default:           state_d = ST_PUSH;
        endcase
      end
      ST_DIVT:  if (stat_i.done) state_d = ST_DIVA;
      ST_DIVA:  if (stat_i.done) state_d = ST_DELTA;
      ST_DELTA: state_d = ST_DECAY;
      ST_DECAY: begin
        if (stat_i.val_zero) begin
          state_d = ST_FIN;
        end else if (stat_i.delta_zero) begin
          state_d = ST_NDT;
        end else begin
          state_d = ST_NHL;
        end
      end
      ST_NHL:   if (stat_i.done) state_d = ST_MDUR;
      ST_MDUR:  if (stat_i.done) state_d = stat_i.delta_gt1 ? ST_MFULL : ST_NRT;
      ST_MFULL: if (stat_i.done) state_d = ST_NRT;
      ST_NRT:   if (stat_i.done) state_d = ST_MNORM;
      ST_NDT:   if (stat_i.done) state_d = ST_MNORM;
      ST_MNORM: if (stat_i.done) state_d = ST_FIN;
      ST_FIN: begin
        if (stat_i.cmd == CMD_READ && !stat_i.rt_zero) begin
          state_d = ST_RNRT;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_RNRT:  if (stat_i.done) state_d = ST_MW;
      ST_MW:    if (stat_i.done) state_d = ST_PUSH;
      ST_SV:    if (stat_i.done) state_d = ST_SO;
      ST_SO:    if (stat_i.done) state_d = ST_SC;
      ST_SC:    if (stat_i.done) state_d = ST_FIN;
      ST_PUSH:  if (stat_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    long_op       = 1'b0;
    cmd_o.op      = OP_NONE;
    cmd_o.div_sel = DIV_T;
    cmd_o.mul_sel = MUL_DUR;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      ST_DIVT: begin
        long_op       = 1'b1;
        cmd_o.div_sel = DIV_T;
      end
      ST_DIVA: begin
        long_op       = 1'b1;
        cmd_o.div_sel = DIV_AT;
      end
      ST_DELTA: cmd_o.op = OP_DELTA;
      ST_DECAY: if (!stat_i.delta_zero) cmd_o.op = OP_DECAY;
      ST_NHL: begin
        long_op       = 1'b1;
        cmd_o.div_sel = DIV_NHL;
      end
      ST_NRT, ST_RNRT: begin
        long_op       = 1'b1;
        cmd_o.div_sel = DIV_NRT;
      end
      ST_NDT: begin
        long_op       = 1'b1;
        cmd_o.div_sel = DIV_NDT;
      end
      ST_MDUR: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_DUR;
      end
      ST_MFULL: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_FULL;
      end
      ST_MNORM: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_NORM;
      end
      ST_MW: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_W;
      end
      ST_SV: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_SV;
      end
      ST_SO: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_SO;
      end
      ST_SC: begin
        long_op       = 1'b1;
        cmd_o.mul_sel = MUL_SC;
      end
      ST_FIN: begin
        unique case (stat_i.cmd)
          CMD_ACC:   cmd_o.op = OP_COMMIT_ACC;
          CMD_SCALE: cmd_o.op = OP_COMMIT_SCL;
          CMD_READ:  if (stat_i.rt_zero) cmd_o.op = OP_RES_O;
          default:   cmd_o.op = OP_NONE;
        endcase
      end
      ST_PUSH: if (stat_i.out_free) cmd_o.op = OP_PUSH;
      default: cmd_o.op = OP_NONE;
    endcase
    if (long_op && !wait_q) begin
      unique case (state_q)
        ST_DIVT, ST_DIVA, ST_NHL, ST_NRT, ST_RNRT, ST_NDT: cmd_o.op = OP_DIV;
        default: cmd_o.op = OP_MUL;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (stat_i.done) begin
        wait_q <= 1'b0;
      end else if (cmd_o.op == OP_DIV || cmd_o.op == OP_MUL) begin
        wait_q <= 1'b1;
      end
    end
  end

endmodule

@@ hdl/decaying_running_average.sv @@
// Top level of the decaying running average with its register port.
//
// Items arrive on the s_axis channel: tuser carries the command (accumulate,
// read or scale), tdata the new value, timestamp, scale factor and shift.
// Each transfer in gives exactly one transfer out on m_axis, whose tdata is
// the blended average for a read and zero otherwise.
// One item is worked on at a time. An accumulate or read is dominated by
// the bit-serial divider, which it uses for up to five divisions by the
// half-life. The result waits in an output register, so the next item can
// be taken while it is held; when the receiver stalls and a second result
// is ready, the block holds until the first one is taken. Reset clears the
// held value, timestamp and both sums, and loads the half-life register
// with its default; pready is always high. The user must write the
// half-life over the APB port only while the block is idle; the block
// itself does not enforce this.
module decaying_running_average
  import dra_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = FracBitsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // new_value [63:0], timestamp [127:64], scale_mult [159:128],
  // scale_shift [165:160], zero [167:166]
  input  logic [167:0] s_axis_tdata,
  // cmd [1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // average [63:0]
  output logic [63:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [31:0] half_life_q;
  dp_cmd_t     dp_cmd;
  dp_stat_t    dp_stat;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrHalfLife) ? half_life_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_life_q <= HalfLifeRst;
    end else if (psel && penable && pwrite && pready && paddr == AddrHalfLife) begin
      half_life_q <= pwdata;
    end
  end

  dra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  dra_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .stat_o           (dp_stat),
    .half_life_i      (half_life_q),
    .in_cmd_i         (s_axis_tuser),
    .in_new_value_i   (s_axis_tdata[63:0]),
    .in_timestamp_i   (s_axis_tdata[127:64]),
    .in_scale_mult_i  (s_axis_tdata[159:128]),
    .in_scale_shift_i (s_axis_tdata[165:160]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_average_o    (m_axis_tdata)
  );

endmodule

@@ hdl/dra_checker.sv @@
// Port-level checker for the decaying running average, bound to the top level.
`include "decaying_running_average_defines.svh"

module dra_port_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [167:0] s_axis_tdata,
  input logic [1:0]   s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [63:0]  m_axis_tdata,
  input logic         psel,
  input logic         penable,
  input logic         pwrite,
  input logic [2:0]   paddr,
  input logic [31:0]  pwdata,
  input logic [31:0]  prdata,
  input logic         pready
);

  `DRA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `DRA_ASSERT(a_busy_after_in, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while busy")
  `DRA_ASSERT(a_no_out_at_accept, s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid), "result raised too early")
  `DRA_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind decaying_running_average dra_port_checker u_dra_port_checker (.*);

@@ bench/dra_checker.sv @@
// Checker for the decaying running average: predicts each result and compares it.
module dra_checker
  import dra_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC = FracBitsDef;
  localparam logic [63:0] ONE_FX = 64'd1 << FRAC;
  localparam logic [63:0] VALUE_LIM = (64'd1 << ValueBitsDef) - 64'd1;

  typedef struct packed {
    logic [63:0] held;
    logic [63:0] at;
    logic [63:0] old_sum;
    logic [63:0] cur_sum;
  } avg_state_t;

  logic [31:0] half_life_q;
  avg_state_t  avg_q;
  logic [63:0] average_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o = average_q.size();

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] decay(logic [63:0] x, logic [63:0] n);
    return (n >= 64) ? 64'd0 : (x >> n);
  endfunction

  function automatic logic [63:0] mul_shift(logic [63:0] x, logic [31:0] m, logic [5:0] sh);
    logic [95:0] p;
    p = {32'd0, x} * {64'd0, m};
    p = p >> sh;
    return (p[95:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] norm_dur(logic [63:0] d, logic [63:0] hl);
    logic [63:0] sh;
    sh = d << FRAC;
    return sh / hl;
  endfunction

  function automatic logic [63:0] period_sum(logic [63:0] idx);
    if (idx > FRAC - 1) idx = FRAC - 1;
    return ONE_FX - (ONE_FX >> (idx + 1));
  endfunction

  function automatic avg_state_t fold(avg_state_t s, logic [63:0] newv, logic [63:0] t,
                                      logic [63:0] hl);
    logic [63:0] delta, dur;
    delta = t / hl - s.at / hl;
    if (delta > 0) begin
      s.old_sum = sat_add(decay(s.old_sum, delta), decay(s.cur_sum, delta));
      s.cur_sum = 0;
    end
    if (s.held != 0) begin
      if (delta > 0) begin
        dur = norm_dur(hl - s.at % hl, hl);
        s.old_sum = sat_add(s.old_sum, mul_shift(s.held, 32'(decay(dur, delta)), 6'd0));
        if (delta > 1)
          s.old_sum = sat_add(s.old_sum,
                              mul_shift(s.held, 32'(period_sum(delta - 2)), 6'd0));
        s.cur_sum = sat_add(s.cur_sum, mul_shift(s.held, 32'(norm_dur(t % hl, hl)), 6'd0));
      end else begin
        s.cur_sum = sat_add(s.cur_sum,
                            mul_shift(s.held, 32'(norm_dur(t - s.at, hl)), 6'd0));
      end
    end
    s.held = (newv > VALUE_LIM) ? VALUE_LIM : newv;
    s.at = t;
    return s;
  endfunction

  function automatic logic [63:0] predict_average(cmd_e cmd, logic [167:0] d);
    logic [63:0] newv, t, hl, elapsed, w;
    logic [31:0] mult;
    logic [5:0]  sh;
    avg_state_t  s;
    newv = d[63:0];
    t = d[127:64];
    mult = d[159:128];
    sh = d[165:160];
    hl = (half_life_q == 0) ? 64'd1 : {32'd0, half_life_q};
    if (t < avg_q.at) t = avg_q.at;
    case (cmd)
      CMD_ACC: avg_q = fold(avg_q, newv, t, hl);
      CMD_READ: begin
        elapsed = t % hl;
        s = fold(avg_q, 64'd0, t, hl);
        if (elapsed != 0) begin
          w = ONE_FX - norm_dur(elapsed, hl) / 2;
          return sat_add(mul_shift(s.old_sum, w[31:0], 6'(FRAC)), s.cur_sum / 2);
        end
        return s.old_sum;
      end
      CMD_SCALE: begin
        avg_q.held = mul_shift(avg_q.held, mult, sh);
        avg_q.old_sum = mul_shift(avg_q.old_sum, mult, sh);
        avg_q.cur_sum = mul_shift(avg_q.cur_sum, mult, sh);
      end
      default: ;
    endcase
    return 64'd0;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_life_q <= HalfLifeRst;
      avg_q = '0;
      average_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrHalfLife)
        half_life_q <= pwdata;
      if (s_axis_tvalid && s_axis_tready)
        average_q.push_back(predict_average(cmd_e'(s_axis_tuser), s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (average_q.size() == 0) report("unexpected transfer", m_axis_tdata, 64'd0);
        else begin
          if (m_axis_tdata !== average_q[0]) report("average", m_axis_tdata, average_q[0]);
          void'(average_q.pop_front());
        end
      end
    end
  end
endmodule

@@ bench/tb_top.sv @@
// Testbench top for the decaying running average: stimulus, handshakes and verdict.
module tb_top
  import dra_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = CMD_NOP;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count, pending;
  int           send_idle_pct, recv_stall_pct;
  logic [63:0]  time_now;
  logic [31:0]  hl_now;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decaying_running_average dut (.*);

  dra_checker checker_i (.*, .fail_count_o(fail_count), .pending_o(pending));

  always @(posedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic write_half_life(logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= AddrHalfLife; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    hl_now = value;
  endtask

  task automatic send(cmd_e cmd, logic [63:0] newv, logic [63:0] ts, logic [31:0] mult,
                      logic [5:0] sh);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, sh, mult, ts, newv};
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    if (ts > time_now && (cmd == CMD_ACC)) time_now = ts;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_item(bit wild_time);
    int unsigned pick;
    logic [63:0] ts, hl;
    cmd_e cmd;
    hl = (hl_now == 0) ? 64'd1 : {32'd0, hl_now};
    pick = $urandom_range(99);
    cmd = (pick < 45) ? CMD_ACC : (pick < 80) ? CMD_READ : (pick < 95) ? CMD_SCALE : CMD_NOP;
    pick = $urandom_range(99);
    if (wild_time) ts = rand64();
    else if (pick < 40) ts = time_now + ((hl / 4) * $urandom_range(0, 4) + $urandom_range(0, 99));
    else if (pick < 70) ts = time_now + hl * $urandom_range(0, 3) + $urandom % hl;
    else if (pick < 85) ts = time_now + hl * $urandom_range(0, 70);
    else if (pick < 95) ts = time_now - $urandom_range(0, 1000);
    else ts = time_now + (hl / hl) * (hl * $urandom_range(0, 3));
    send(cmd, rand64() >> $urandom_range(0, 63), ts,
         ($urandom_range(3) == 0) ? $urandom : ($urandom_range(0, 3) << $urandom_range(0, 30)),
         $urandom_range(0, 63));
  endtask

  initial begin
    logic [31:0] hl_set [6];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    time_now = 0;
    hl_now = HalfLifeRst;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_half_life(32'd1000);
    send(CMD_READ, 0, 0, 0, 0);
    send(CMD_ACC, '1, 500, 0, 0);
    send(CMD_READ, 0, 700, 0, 0);
    send(CMD_READ, 0, 2000, 0, 0);
    send(CMD_ACC, 64'd12345, 3250, 0, 0);
    send(CMD_ACC, 64'hFFFFF, 100, 0, 0);
    send(CMD_READ, 0, 50, 0, 0);
    send(CMD_ACC, 64'hABCDE, 9999, 0, 0);
    send(CMD_READ, 0, 80000, 0, 0);
    send(CMD_ACC, 64'h0FFF_FFFF_FFFF, 80001, 0, 0);
    send(CMD_SCALE, '1, 0, 32'hFFFF_FFFF, 6'd0);
    send(CMD_READ, 0, 80500, 0, 0);
    send(CMD_SCALE, '1, '1, 32'hFFFF_FFFF, 6'd63);
    send(CMD_NOP, '1, '1, '1, '1);
    send(CMD_SCALE, 0, 0, 32'd3, 6'd1);
    send(CMD_ACC, 64'd1 << 43, 120000, 0, 0);
    send(CMD_READ, 0, 64'd1 << 40, 0, 0);
    send(CMD_SCALE, 0, 0, 32'h0, 6'd0);
    drain();

    hl_set = '{HalfLifeRst, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd777, 32'd0};
    hl_set[5] = $urandom_range(2, 1 << 20);
    for (int p = 0; p < 6; p++) begin
      write_half_life(hl_set[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      repeat (80) random_item(1'b0);
      drain();
    end

    send_idle_pct = 23;
    recv_stall_pct = 23;
    write_half_life($urandom);
    repeat (20) random_item(1'b1);
    send(CMD_READ, 0, '1, 0, 0);
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
